// ----- hdl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Shared wrappers for concurrent assertions on clk_i and rst_ni.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check on every rising edge outside reset.
`define YAWPD_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("yawpd assertion failed");

// Check on every rising edge, reset included.
`define YAWPD_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error("yawpd assertion failed");

`endif

// ----- hdl/yawpd_pkg.sv -----
// ----------------------------------------------------------------------------
// yawpd_pkg
// Types, constants and helpers shared by the yaw PD target loop.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package yawpd_pkg;

  // Fixed-point format of angles and rates
  localparam int FRAC_BITS  = 16;
  localparam int GAIN_FRAC  = 12;
  localparam int RATE_SHIFT = 40 - FRAC_BITS;

  // Field widths
  localparam int KIND_W  = 2;
  localparam int GYRO_W  = 20;
  localparam int MS_W    = 16;
  localparam int VAL_W   = 32;
  localparam int GAIN_W  = 16;
  localparam int LIM_W   = 24;
  localparam int DTMAX_W = 8;

  // Serial multiplier: signed A, unsigned B, signed accumulator
  localparam int MUL_A_W = 32;
  localparam int MUL_B_W = 27;
  localparam int MUL_W   = 50;

  // Serial divide by the millisecond scale
  localparam int DIV_W     = 48;
  localparam int DIV_CNT_W = $clog2(DIV_W + 1);
  localparam int DIV_R_W   = 10;
  localparam int DIVISOR   = 1000;
  localparam int MS_ROUND  = 500;

  localparam logic [MUL_B_W-1:0] DEG2RAD_Q32 = 27'd74961321;
  localparam logic [MUL_W-1:0]   RATE_HALF   = MUL_W'(1) << (RATE_SHIFT - 1);
  localparam logic [MUL_W-1:0]   GAIN_HALF   = MUL_W'(1) << (GAIN_FRAC - 1);

  // Configuration port
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 32;
  localparam logic [CFG_IDX_W-1:0] CFG_PROP_GAIN  = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DERIV_GAIN = 8'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SPEED_CAP  = 8'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DT_MAX     = 8'd3;

  localparam logic [GAIN_W-1:0]  PROP_GAIN_RST  = 16'd8192;
  localparam logic [GAIN_W-1:0]  DERIV_GAIN_RST = 16'd205;
  localparam logic [LIM_W-1:0]   SPEED_CAP_RST  = 24'd327680;
  localparam logic [DTMAX_W-1:0] DT_MAX_RST     = 8'd100;

  typedef enum logic [KIND_W-1:0] {
    KIND_TICK  = 2'd0,
    KIND_START = 2'd1,
    KIND_STOP  = 2'd2
  } kind_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RATE,
    ST_YAW_MUL,
    ST_YAW_DIV,
    ST_P_MUL,
    ST_D_MUL,
    ST_T_MUL,
    ST_T_DIV,
    ST_EMIT
  } state_e;

  typedef struct packed {
    logic [KIND_W-1:0]       kind;
    logic signed [GYRO_W-1:0] gyro_z;
    logic [MS_W-1:0]         elapsed_ms;
    logic signed [VAL_W-1:0] start_position;
  } in_item_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] target_position;
    logic signed [VAL_W-1:0] yaw_angle;
    logic signed [VAL_W-1:0] yaw_rate;
    logic                    velocity_clamped;
  } out_item_t;

  typedef struct packed {
    logic                      start;
    logic [MUL_A_W-1:0]        a;
    logic [MUL_B_W-1:0]        b;
    logic [MUL_W-1:0]          init;
  } mul_req_t;

  typedef struct packed {
    logic             done;
    logic [MUL_W-1:0] prod;
  } mul_rsp_t;

  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] mag;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DIV_W-1:0] quot;
  } div_rsp_t;

  // Saturate a wide two's-complement value to 32 bits
  function automatic logic [VAL_W-1:0] sat32(input logic [MUL_W-1:0] x);
    logic [VAL_W-1:0] r;
    if (x[MUL_W-1:VAL_W-1] == '0 || x[MUL_W-1:VAL_W-1] == '1) begin
      r = x[VAL_W-1:0];
    end else if (x[MUL_W-1]) begin
      r = {1'b1, {(VAL_W-1){1'b0}}};
    end else begin
      r = {1'b0, {(VAL_W-1){1'b1}}};
    end
    return r;
  endfunction

endpackage

// ----- hdl/yawpd_mul.sv -----
// ----------------------------------------------------------------------------
// yawpd_mul
// Shift-add multiplier, one multiplier bit per cycle, accumulating onto init.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module yawpd_mul (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  yawpd_pkg::mul_req_t req_i,
  output yawpd_pkg::mul_rsp_t rsp_o
);
  import yawpd_pkg::*;

  logic               busy_q;
  logic [MUL_W-1:0]   acc_q;
  logic [MUL_W-1:0]   a_q;
  logic [MUL_B_W-1:0] b_q;
  logic               last;

  assign last = busy_q && (b_q == '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
    end else if (req_i.start) begin
      busy_q <= 1'b1;
    end else if (last) begin
      busy_q <= 1'b0;
    end
  end

  // Retire one multiplier bit per cycle; stop once no set bits remain
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      acc_q <= req_i.init;
      a_q   <= {{(MUL_W-MUL_A_W){req_i.a[MUL_A_W-1]}}, req_i.a};
      b_q   <= req_i.b;
    end else if (busy_q && !last) begin
      if (b_q[0]) begin
        acc_q <= acc_q + a_q;
      end
      a_q <= a_q << 1;
      b_q <= b_q >> 1;
    end
  end

  assign rsp_o.done = last;
  assign rsp_o.prod = acc_q;

endmodule

// ----- hdl/yawpd_div.sv -----
// ----------------------------------------------------------------------------
// yawpd_div
// Restoring divider by the millisecond scale, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module yawpd_div (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  yawpd_pkg::div_req_t req_i,
  output yawpd_pkg::div_rsp_t rsp_o
);
  import yawpd_pkg::*;

  logic                 busy_q;
  logic [DIV_CNT_W-1:0] cnt_q;
  logic [DIV_R_W-1:0]   rem_q;
  logic [DIV_W-1:0]     dvd_q;
  logic [DIV_R_W:0]     trial;
  logic                 ge;
  logic                 last;

  assign last  = busy_q && (cnt_q == '0);
  assign trial = {rem_q, dvd_q[DIV_W-1]};
  assign ge    = trial >= (DIV_R_W+1)'(DIVISOR);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (req_i.start) begin
      busy_q <= 1'b1;
      cnt_q  <= DIV_CNT_W'(DIV_W);
    end else if (last) begin
      busy_q <= 1'b0;
    end else if (busy_q) begin
      cnt_q <= cnt_q - 1'b1;
    end
  end

  // Quotient bits shift in behind the dividend
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q <= '0;
      dvd_q <= req_i.mag;
    end else if (busy_q && !last) begin
      if (ge) begin
        rem_q <= DIV_R_W'(trial - (DIV_R_W+1)'(DIVISOR));
      end else begin
        rem_q <= trial[DIV_R_W-1:0];
      end
      dvd_q <= {dvd_q[DIV_W-2:0], ge};
    end
  end

  assign rsp_o.done = last;
  assign rsp_o.quot = dvd_q;

endmodule

// ----- hdl/yaw_pd_position_target_loop_unit.sv -----
// ----------------------------------------------------------------------------
// yaw_pd_position_target_loop_unit
// Gyro-driven PD loop that integrates a clamped velocity into a motor target.
// ----------------------------------------------------------------------------
//
//  Channel | Direction | Handshake              | Word
//  --------+-----------+------------------------+------------------------------
//  in      | input     | in_valid_i / in_ready_o | in_item_t: kind, gyro, ms, pos
//  out     | output    | out_valid_o/out_ready_i | out_item_t: target, yaw, rate, clamp
//  cfg     | input     | cfg_valid_i/cfg_ready_o | register index and data
//
//  A start, stop or rejected tick word leaves the input open. An accepted tick
//  holds the input closed while it runs: five passes through the shift-add
//  multiplier (one multiplier bit a cycle, at most 27 bits) and two 48-step
//  divides by 1000; its result then goes on to the output register.
//  Reset clears the loop state and returns the configuration registers to their defaults.
//  A finished result waits in the output register; the next word is taken
//  meanwhile, and a tick only stalls at its end if the previous result stays.
//  Configuration words are always taken.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module yaw_pd_position_target_loop_unit (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  yawpd_pkg::in_item_t                 in_data_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output yawpd_pkg::out_item_t                out_data_o,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [yawpd_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [yawpd_pkg::CFG_DATA_W-1:0]    cfg_data_i
);
  import yawpd_pkg::*;

  // Configuration registers
  logic [GAIN_W-1:0]  prop_gain_q;
  logic [GAIN_W-1:0]  deriv_gain_q;
  logic [LIM_W-1:0]   speed_cap_q;
  logic [DTMAX_W-1:0] dt_max_q;

  // Loop state
  state_e                  state_q, state_d;
  logic                    active_q, active_d;
  logic signed [VAL_W-1:0] yaw_q, yaw_d;
  logic signed [VAL_W-1:0] rate_q, rate_d;
  logic signed [VAL_W-1:0] target_q, target_d;

  // Per-tick working registers
  logic [MS_W-1:0] ms_q, ms_d;
  logic            neg_q, neg_d;
  logic            clamped_q, clamped_d;

  // Output register
  logic      out_valid_q, out_valid_d;
  out_item_t out_data_q, out_data_d;

  mul_req_t mul_req;
  mul_rsp_t mul_rsp;
  div_req_t div_req;
  div_rsp_t div_rsp;

  logic                    in_acc;
  logic                    tick_ok;
  logic signed [MUL_W-1:0] prod;
  logic [MUL_W-1:0]        prod_abs;
  logic [DIV_W-1:0]        div_mag;
  logic signed [MUL_W-1:0] rate_sh;
  logic signed [VAL_W-1:0] rate_new;
  logic signed [MUL_W-1:0] quot_ext;
  logic signed [MUL_W-1:0] quot_s;
  logic signed [VAL_W-1:0] yaw_new;
  logic signed [VAL_W-1:0] target_new;
  logic signed [MUL_W-1:0] pd_sh;
  logic signed [MUL_W-1:0] u_raw;
  logic signed [MUL_W-1:0] lim_s;
  logic                    u_hi;
  logic                    u_lo;
  logic signed [MUL_W-1:0] u_clamp;

  yawpd_mul u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mul_req),
    .rsp_o  (mul_rsp)
  );

  yawpd_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  assign in_ready_o  = (state_q == ST_IDLE);
  assign in_acc      = in_valid_i && in_ready_o;
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // Tick is used only while active and within the allowed interval
  assign tick_ok = (in_data_i.kind == KIND_TICK) && active_q &&
                   (in_data_i.elapsed_ms != '0) &&
                   (in_data_i.elapsed_ms <= MS_W'(dt_max_q));

  // Product post-processing
  assign prod     = mul_rsp.prod;
  assign prod_abs = prod[MUL_W-1] ? MUL_W'(-prod) : MUL_W'(prod);
  // Magnitude plus half the scale: rounds half away from zero on the divide
  assign div_mag  = prod_abs[DIV_W-1:0] + DIV_W'(MS_ROUND);

  // deg/s to rad/s, rounding offset already in the accumulator
  assign rate_sh  = prod >>> RATE_SHIFT;
  assign rate_new = sat32(rate_sh);

  // Signed scaled increment, added onto yaw or target with saturation
  assign quot_ext   = {{(MUL_W-DIV_W){1'b0}}, div_rsp.quot};
  assign quot_s     = neg_q ? -quot_ext : quot_ext;
  assign yaw_new    = sat32({{(MUL_W-VAL_W){yaw_q[VAL_W-1]}}, yaw_q} + quot_s);
  assign target_new = sat32({{(MUL_W-VAL_W){target_q[VAL_W-1]}}, target_q} + quot_s);

  // PD velocity: negate, then clamp to the limit
  assign pd_sh   = prod >>> GAIN_FRAC;
  assign u_raw   = -pd_sh;
  assign lim_s   = {{(MUL_W-LIM_W){1'b0}}, speed_cap_q};
  assign u_hi    = u_raw > lim_s;
  assign u_lo    = u_raw < -lim_s;
  assign u_clamp = u_hi ? lim_s : (u_lo ? -lim_s : u_raw);

  // Sequencer
  always_comb begin
    state_d     = state_q;
    active_d    = active_q;
    yaw_d       = yaw_q;
    rate_d      = rate_q;
    target_d    = target_q;
    ms_d        = ms_q;
    neg_d       = neg_q;
    clamped_d   = clamped_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_data_d  = out_data_q;
    mul_req     = '0;
    div_req     = '0;

    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          if (in_data_i.kind == KIND_START) begin
            target_d = in_data_i.start_position;
            yaw_d    = '0;
            rate_d   = '0;
            active_d = 1'b1;
          end else if (in_data_i.kind == KIND_STOP) begin
            active_d = 1'b0;
          end else if (tick_ok) begin
            ms_d          = in_data_i.elapsed_ms;
            mul_req.start = 1'b1;
            mul_req.a     = {{(MUL_A_W-GYRO_W){in_data_i.gyro_z[GYRO_W-1]}},
                             in_data_i.gyro_z};
            mul_req.b     = DEG2RAD_Q32;
            mul_req.init  = RATE_HALF;
            state_d       = ST_RATE;
          end
        end
      end
      ST_RATE: begin
        if (mul_rsp.done) begin
          rate_d        = rate_new;
          mul_req.start = 1'b1;
          mul_req.a     = rate_new;
          mul_req.b     = MUL_B_W'(ms_q);
          state_d       = ST_YAW_MUL;
        end
      end
      ST_YAW_MUL: begin
        if (mul_rsp.done) begin
          neg_d         = prod[MUL_W-1];
          div_req.start = 1'b1;
          div_req.mag   = div_mag;
          state_d       = ST_YAW_DIV;
        end
      end
      ST_YAW_DIV: begin
        if (div_rsp.done) begin
          yaw_d         = yaw_new;
          mul_req.start = 1'b1;
          mul_req.a     = yaw_new;
          mul_req.b     = MUL_B_W'(prop_gain_q);
          mul_req.init  = GAIN_HALF;
          state_d       = ST_P_MUL;
        end
      end
      ST_P_MUL: begin
        if (mul_rsp.done) begin
          // Add the rate term onto the proportional product
          mul_req.start = 1'b1;
          mul_req.a     = rate_q;
          mul_req.b     = MUL_B_W'(deriv_gain_q);
          mul_req.init  = prod;
          state_d       = ST_D_MUL;
        end
      end
      ST_D_MUL: begin
        if (mul_rsp.done) begin
          clamped_d     = u_hi || u_lo;
          mul_req.start = 1'b1;
          mul_req.a     = u_clamp[MUL_A_W-1:0];
          mul_req.b     = MUL_B_W'(ms_q);
          state_d       = ST_T_MUL;
        end
      end
      ST_T_MUL: begin
        if (mul_rsp.done) begin
          neg_d         = prod[MUL_W-1];
          div_req.start = 1'b1;
          div_req.mag   = div_mag;
          state_d       = ST_T_DIV;
        end
      end
      ST_T_DIV: begin
        if (div_rsp.done) begin
          target_d = target_new;
          state_d  = ST_EMIT;
        end
      end
      ST_EMIT: begin
        // Hold until the output register is free
        if (!out_valid_q || out_ready_i) begin
          out_valid_d                 = 1'b1;
          out_data_d.target_position  = target_q;
          out_data_d.yaw_angle        = yaw_q;
          out_data_d.yaw_rate         = rate_q;
          out_data_d.velocity_clamped = clamped_q;
          state_d                     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      active_q    <= 1'b0;
      yaw_q       <= '0;
      rate_q      <= '0;
      target_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      active_q    <= active_d;
      yaw_q       <= yaw_d;
      rate_q      <= rate_d;
      target_q    <= target_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    ms_q       <= ms_d;
    neg_q      <= neg_d;
    clamped_q  <= clamped_d;
    out_data_q <= out_data_d;
  end

  // Configuration writes; unknown indexes drop
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prop_gain_q  <= PROP_GAIN_RST;
      deriv_gain_q <= DERIV_GAIN_RST;
      speed_cap_q  <= SPEED_CAP_RST;
      dt_max_q     <= DT_MAX_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CFG_PROP_GAIN:  prop_gain_q  <= cfg_data_i[GAIN_W-1:0];
        CFG_DERIV_GAIN: deriv_gain_q <= cfg_data_i[GAIN_W-1:0];
        CFG_SPEED_CAP:  speed_cap_q  <= cfg_data_i[LIM_W-1:0];
        CFG_DT_MAX:     dt_max_q     <= cfg_data_i[DTMAX_W-1:0];
        default: begin
        end
      endcase
    end
  end

endmodule

// ----- hdl/yawpd_checker.sv -----
// ----------------------------------------------------------------------------
// yawpd_checker
// Port-level checks on the yaw PD target loop, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module yawpd_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             in_valid_i,
  input logic                             in_ready_o,
  input yawpd_pkg::in_item_t              in_data_i,
  input logic                             out_valid_o,
  input logic                             out_ready_i,
  input yawpd_pkg::out_item_t             out_data_o
);
  import yawpd_pkg::*;

  // A stalled result word stays offered
  `YAWPD_ASSERT(a_out_hold, (out_valid_o && !out_ready_i) |=> out_valid_o)

  // A stalled result word keeps its value
  `YAWPD_ASSERT(a_out_stable, (out_valid_o && !out_ready_i) |=> $stable(out_data_o))

  // A result never follows the word accepted just before it
  `YAWPD_ASSERT(a_no_fast_result, $rose(out_valid_o) |-> !$past(in_valid_i && in_ready_o))

  // A start word leaves the input open
  `YAWPD_ASSERT(a_start_ready,
    (in_valid_i && in_ready_o && in_data_i.kind == KIND_START) |=> in_ready_o)

  // No result is offered while reset is held
  `YAWPD_ASSERT_ALWAYS(a_reset_quiet, !rst_ni |-> !out_valid_o)

endmodule

bind yaw_pd_position_target_loop_unit yawpd_checker u_yawpd_checker (.*);
